FILE: sv/packed_glyph_rasterizer_core_assert.svh
// ----------------------------------------------------------------------------
// Packed glyph rasterizer assertion macros
// Shared concurrent assertion forms for the rasterizer modules.
// ----------------------------------------------------------------------------
`ifndef PACKED_GLYPH_RASTERIZER_CORE_ASSERT_SVH
`define PACKED_GLYPH_RASTERIZER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PGR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define PGR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/pgr_pkg.sv
// ----------------------------------------------------------------------------
// Packed glyph rasterizer package
// Shared constants, register indexes and the front-to-back job type.
// ----------------------------------------------------------------------------
`default_nettype none

package pgr_pkg;

   // number of glyphs in the font before the search gives up
   localparam logic [7:0] GLYPH_COUNT = 8'd222;

   // job queue between parser and pixel expander
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // configuration register indexes
   localparam logic [2:0] CSR_TARGET_GLYPH = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_X     = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Y     = 3'd2;
   localparam logic [2:0] CSR_INK_COLOR    = 3'd3;
   localparam logic [2:0] CSR_GLYPH_HEIGHT = 3'd4;

   // result kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   typedef struct packed {
      logic [7:0]  target_glyph;
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [7:0]  ink_color;
      logic [6:0]  glyph_height;
   } cfg_type;

   // one parsed byte worth of work for the back end
   typedef struct packed {
      logic [7:0]  bits;        // pixel bits still to draw, MSB first
      logic [1:0]  shift;       // log2 of glyph width
      logic [13:0] y_base;      // row offset of this data byte
      logic        has_done;    // glyph done result follows the pixels
      logic [7:0]  done_width;  // width carried by the done result
   } job_type;

endpackage

`default_nettype wire

FILE: sv/pgr_front.sv
// ----------------------------------------------------------------------------
// Packed glyph rasterizer front end
// Parses the font byte stream and posts pixel and done jobs to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pgr_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire pgr_pkg::cfg_type cfg,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire  [7:0]           req_font_byte,
   input  wire                  req_stream_start,
   input  wire                  q_full,
   output logic                 q_push,
   output pgr_pkg::job_type     q_job
);

   logic [7:0]  glyph_counter_ff, glyph_counter_in;
   logic        expect_width_ff, expect_width_in;
   logic [10:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  current_width_ff, current_width_in;
   logic [10:0] data_byte_index_ff, data_byte_index_in;
   logic        finished_ff, finished_in;

   logic        accept;
   logic [7:0]  cnt_e, cw_e;
   logic        expw_e, fin_e;
   logic [10:0] bl_e, idx_e, bl_dec;
   logic [14:0] glyph_len_prod;
   logic [10:0] glyph_len;
   logic        ends, is_target, width_ok;
   logic [1:0]  shift;
   logic [7:0]  cnt_inc;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // state as seen after an optional stream restart
   always_comb begin
      cnt_e  = req_stream_start ? 8'd0  : glyph_counter_ff;
      expw_e = req_stream_start ? 1'b1  : expect_width_ff;
      bl_e   = req_stream_start ? 11'd0 : bytes_left_ff;
      cw_e   = req_stream_start ? 8'd0  : current_width_ff;
      idx_e  = req_stream_start ? 11'd0 : data_byte_index_ff;
      fin_e  = req_stream_start ? 1'b0  : finished_ff;
   end

   assign glyph_len_prod = 15'(cfg.glyph_height) * 15'(req_font_byte);
   assign glyph_len      = glyph_len_prod[13:3];
   assign bl_dec         = bl_e - 11'd1;
   assign is_target      = (cnt_e == cfg.target_glyph);
   assign cnt_inc        = cnt_e + 8'd1;

   // width decode: only power-of-two widths up to 8 draw
   always_comb begin
      width_ok = 1'b1;
      shift    = 2'd0;
      case (cw_e)
         8'd1:    shift = 2'd0;
         8'd2:    shift = 2'd1;
         8'd4:    shift = 2'd2;
         8'd8:    shift = 2'd3;
         default: width_ok = 1'b0;
      endcase
   end

   // parse step
   always_comb begin
      glyph_counter_in   = cnt_e;
      expect_width_in    = expw_e;
      bytes_left_in      = bl_e;
      current_width_in   = cw_e;
      data_byte_index_in = idx_e;
      finished_in        = fin_e;
      ends               = 1'b0;
      q_job              = '0;
      q_job.shift        = shift;
      q_job.y_base       = 14'(idx_e) << (2'd3 - shift);

      if (!fin_e) begin
         if (expw_e) begin
            current_width_in   = req_font_byte;
            bytes_left_in      = glyph_len;
            data_byte_index_in = 11'd0;
            expect_width_in    = 1'b0;
            ends               = (glyph_len == 11'd0);
         end else begin
            if (is_target && width_ok) begin
               q_job.bits = req_font_byte;
            end
            data_byte_index_in = idx_e + 11'd1;
            bytes_left_in      = bl_dec;
            ends               = (bl_dec == 11'd0);
         end

         // glyph ends on this byte
         if (ends) begin
            if (is_target) begin
               q_job.has_done   = 1'b1;
               q_job.done_width = current_width_in;
               finished_in      = 1'b1;
            end else begin
               glyph_counter_in = cnt_inc;
               expect_width_in  = 1'b1;
               if (cnt_inc >= pgr_pkg::GLYPH_COUNT) begin
                  q_job.has_done   = 1'b1;
                  q_job.done_width = 8'd0;
                  finished_in      = 1'b1;
               end
            end
         end
      end
   end

   assign q_push = accept && ((q_job.bits != 8'd0) || q_job.has_done);

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_counter_ff   <= 8'd0;
         expect_width_ff    <= 1'b1;
         bytes_left_ff      <= 11'd0;
         current_width_ff   <= 8'd0;
         data_byte_index_ff <= 11'd0;
         finished_ff        <= 1'b0;
      end else if (accept) begin
         glyph_counter_ff   <= glyph_counter_in;
         expect_width_ff    <= expect_width_in;
         bytes_left_ff      <= bytes_left_in;
         current_width_ff   <= current_width_in;
         data_byte_index_ff <= data_byte_index_in;
         finished_ff        <= finished_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/pgr_queue.sv
// ----------------------------------------------------------------------------
// Packed glyph rasterizer job queue
// Small FIFO that decouples the stream parser from the pixel expander.
// ----------------------------------------------------------------------------
`default_nettype none

module pgr_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wire pgr_pkg::job_type push_job,
   input  wire                  pop,
   output logic                 full,
   output logic                 not_empty,
   output pgr_pkg::job_type     head_job
);

   `include "packed_glyph_rasterizer_core_assert.svh"

   pgr_pkg::job_type            mem_ff [pgr_pkg::QUEUE_DEPTH];
   logic [pgr_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [pgr_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [pgr_pkg::QCNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == pgr_pkg::QCNT_W'(pgr_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   `PGR_ASSERT_IMPLY(a_no_push_full, clock, reset, push, !full || pop, "push into full queue")
   `PGR_ASSERT_IMPLY(a_no_pop_empty, clock, reset, pop, not_empty, "pop from empty queue")
   `PGR_ASSERT_NEXT(a_count_step, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "fill count missed a push")

endmodule

`default_nettype wire

FILE: sv/pgr_back.sv
// ----------------------------------------------------------------------------
// Packed glyph rasterizer back end
// Registers one result per cycle from queued jobs unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pgr_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire pgr_pkg::cfg_type cfg,
   input  wire                  q_not_empty,
   input  wire pgr_pkg::job_type q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic                 rsp_result_kind,
   output logic [15:0]          rsp_pixel_x,
   output logic [15:0]          rsp_pixel_y,
   output logic [7:0]           rsp_pixel_color,
   output logic [7:0]           rsp_glyph_width,
   output logic                 rsp_last_of_item
);

   `include "packed_glyph_rasterizer_core_assert.svh"

   logic              cur_valid_ff, cur_valid_in;
   pgr_pkg::job_type  cur_ff, cur_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              kind_ff, kind_in;
   logic [15:0]       x_ff, x_in;
   logic [15:0]       y_ff, y_in;
   logic [7:0]        color_ff, color_in;
   logic [7:0]        width_ff, width_in;
   logic              last_ff, last_in;

   pgr_pkg::job_type  src;
   logic              src_valid, out_free, fire, remaining;
   logic [2:0]        j;
   logic              found;
   logic [7:0]        bits_next;
   logic [2:0]        col_mask;

   assign src       = cur_valid_ff ? cur_ff : q_head;
   assign src_valid = cur_valid_ff || q_not_empty;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = src_valid && out_free;
   assign q_pop     = fire && !cur_valid_ff;

   // leading set bit, MSB first
   always_comb begin
      j     = 3'd0;
      found = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!found && src.bits[7 - i]) begin
            j     = 3'(i);
            found = 1'b1;
         end
      end
   end

   assign col_mask  = 3'((4'd1 << src.shift) - 4'd1);
   assign bits_next = src.bits & ~(8'h80 >> j);

   // result formation
   always_comb begin
      kind_in      = kind_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      color_in     = color_ff;
      width_in     = width_ff;
      last_in      = last_ff;
      remaining    = 1'b0;
      cur_in       = src;
      cur_in.bits  = bits_next;
      if (found) begin
         kind_in   = pgr_pkg::KIND_PIXEL;
         x_in      = cfg.origin_x + 16'(j & col_mask);
         y_in      = cfg.origin_y + 16'(src.y_base) + 16'(j >> src.shift);
         color_in  = cfg.ink_color;
         width_in  = 8'd0;
         remaining = (bits_next != 8'd0) || src.has_done;
         last_in   = !remaining;
      end else begin
         kind_in   = pgr_pkg::KIND_DONE;
         x_in      = 16'd0;
         y_in      = 16'd0;
         color_in  = 8'd0;
         width_in  = src.done_width;
         last_in   = 1'b1;
      end
   end

   // work-in-progress and output valid
   always_comb begin
      cur_valid_in = cur_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         cur_valid_in = remaining;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (fire) begin
         cur_ff   <= cur_in;
         kind_ff  <= kind_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         color_ff <= color_in;
         width_ff <= width_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_pixel_x      = x_ff;
   assign rsp_pixel_y      = y_ff;
   assign rsp_pixel_color  = color_ff;
   assign rsp_glyph_width  = width_ff;
   assign rsp_last_of_item = last_ff;

   `PGR_ASSERT_IMPLY(a_done_is_last, clock, reset, rsp_valid && (rsp_result_kind == pgr_pkg::KIND_DONE), rsp_last_of_item, "done result not last of item")
   `PGR_ASSERT_IMPLY(a_done_clean, clock, reset, rsp_valid && (rsp_result_kind == pgr_pkg::KIND_DONE), (rsp_pixel_x == 16'd0) && (rsp_pixel_y == 16'd0) && (rsp_pixel_color == 8'd0), "done result carries pixel data")
   `PGR_ASSERT_IMPLY(a_pop_only_idle, clock, reset, q_pop, !cur_valid_ff && out_free, "queue popped while a job is in progress")

endmodule

`default_nettype wire

FILE: sv/packed_glyph_rasterizer_core.sv
// ----------------------------------------------------------------------------
// Packed glyph rasterizer core
// Turns one glyph of a packed variable-width font byte stream into pixels.
// ----------------------------------------------------------------------------
// The font arrives one byte per req transaction. A parser accepts a byte
// every cycle while its two-entry job queue has room, so bytes of skipped
// glyphs and bytes that yield nothing stream at one per cycle. Each byte of
// the target glyph expands in the back end into one rsp transaction per set
// bit, MSB first, followed by the glyph done result where the glyph ends; the
// back end issues one result per cycle through its output register while
// rsp_ready does not stall it, so a target byte with n set bits yields n
// results (n + 1 with the done result, at most 9). A byte's job is queued,
// then its result is registered. Registers are written through the csr port
// (always ready) and must only change while the core is idle.
`default_nettype none

module packed_glyph_rasterizer_core (
   input  wire          clock,
   input  wire          reset,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [2:0]   csr_index,
   input  wire  [15:0]  csr_data,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire  [7:0]   req_font_byte,
   input  wire          req_stream_start,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output logic         rsp_result_kind,
   output logic [15:0]  rsp_pixel_x,
   output logic [15:0]  rsp_pixel_y,
   output logic [7:0]   rsp_pixel_color,
   output logic [7:0]   rsp_glyph_width,
   output logic         rsp_last_of_item
);

   pgr_pkg::cfg_type  cfg_ff, cfg_in;
   logic              q_full, q_push, q_pop, q_not_empty;
   pgr_pkg::job_type  q_job, q_head;

   assign csr_ready = 1'b1;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pgr_pkg::CSR_TARGET_GLYPH: cfg_in.target_glyph = csr_data[7:0];
            pgr_pkg::CSR_ORIGIN_X:     cfg_in.origin_x     = csr_data;
            pgr_pkg::CSR_ORIGIN_Y:     cfg_in.origin_y     = csr_data;
            pgr_pkg::CSR_INK_COLOR:    cfg_in.ink_color    = csr_data[7:0];
            pgr_pkg::CSR_GLYPH_HEIGHT: cfg_in.glyph_height = csr_data[6:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_glyph <= 8'd0;
         cfg_ff.origin_x     <= 16'd0;
         cfg_ff.origin_y     <= 16'd0;
         cfg_ff.ink_color    <= 8'd15;
         cfg_ff.glyph_height <= 7'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pgr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_font_byte    (req_font_byte),
      .req_stream_start (req_stream_start),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_job            (q_job)
   );

   pgr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_job),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_job  (q_head)
   );

   pgr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_not_empty      (q_not_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_glyph_width  (rsp_glyph_width),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule

`default_nettype wire
